// ===== rtl/tfl_pkg.sv =====
// Shared constants, codes and types for the TLB lookup block.
// No dependencies; imported by every module in rtl/.
`default_nettype none

package tfl_pkg;

    localparam int TLB_ENTRIES = 8;
    localparam int OFFSET_BITS = 12;
    localparam int ADDR_W      = 32;
    localparam int FRAME_W     = 20;
    localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
    localparam int IDX_W       = $clog2(TLB_ENTRIES);
    localparam int COUNT_W     = $clog2(TLB_ENTRIES + 1);

    // Stream packing
    localparam int IN_DATA_W   = ((ADDR_W + FRAME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 3 * ADDR_W;

    // Item kinds
    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_FILL      = 1'b1;

    // Replacement policy
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    typedef struct packed {
        logic               fire;
        logic               fill;
        logic               lru;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } tfl_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tfl_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tlb_fifo_lru_lookup.sv =====
// The input register and the result register lie between input transfer and result valid.
// Throughput: one transfer per cycle while m_axis_tready holds; lookup, reorder and fill
// all resolve in the single combinational pass through the tag compare between the two registers.
// Reset (rst_n, async, active low): table empty, both counters zero, FIFO policy.
// Depends on tfl_pkg and tfl_table.
`default_nettype none

module tlb_fifo_lru_lookup (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Policy register write channel
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic                           cfg_data,       // replace_policy

    // Input stream
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [tfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // virt_addr, fill_frame, pad
    input  wire logic                           s_axis_tuser,   // action

    // Result stream
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output      logic [tfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // phys_addr, hits, lookups
    output      logic                           m_axis_tuser    // hit
);
    import tfl_pkg::*;

    // Policy register: the user must write it only while idle (the block does not enforce this), so always ready
    logic policy_reg;

    // Input register
    logic               in_valid_reg;
    logic               in_fill_reg;
    logic [ADDR_W-1:0]  in_addr_reg;
    logic [FRAME_W-1:0] in_frame_reg;

    // Result register and counters
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [ADDR_W-1:0]  out_phys_reg;
    logic [ADDR_W-1:0]  hit_cnt_reg;
    logic [ADDR_W-1:0]  lookup_cnt_reg;

    logic               advance;
    logic               in_take;
    logic               lookup_hit;
    logic [ADDR_W-1:0]  phys;
    logic [FRAME_W+ADDR_W-1:0] phys_wide;

    tfl_req_t req;
    tfl_rsp_t rsp;

    // Stage moves when the result register is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign req.fire  = advance;
    assign req.fill  = (in_fill_reg == ACT_FILL);
    assign req.lru   = (policy_reg == POL_LRU);
    assign req.page  = in_addr_reg[ADDR_W-1:OFFSET_BITS];
    assign req.frame = in_frame_reg;

    tfl_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign lookup_hit = (in_fill_reg == ACT_TRANSLATE) && rsp.hit;

    // Frame joined above the page offset; the frame fills bits 31:12 exactly
    assign phys_wide = ({{ADDR_W{1'b0}}, rsp.frame} << OFFSET_BITS)
                     | (FRAME_W+ADDR_W)'(in_addr_reg[OFFSET_BITS-1:0]);
    assign phys      = lookup_hit ? phys_wide[ADDR_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_fill_reg  <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[ADDR_W-1:0];
            in_frame_reg <= s_axis_tdata[ADDR_W+FRAME_W-1:ADDR_W];
        end
    end

    // Counters only move with a result load, so they always match the held result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            lookup_cnt_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (in_fill_reg == ACT_TRANSLATE)
                begin
                    lookup_cnt_reg <= lookup_cnt_reg + ADDR_W'(1);
                end
                if (lookup_hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + ADDR_W'(1);
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hit_reg  <= lookup_hit;
            out_phys_reg <= phys;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {lookup_cnt_reg, hit_cnt_reg, out_phys_reg};

endmodule

`default_nettype wire

// ===== rtl/tfl_table.sv =====
// Eight-slot age-ordered tag/frame table: parallel compare, FIFO/LRU reorder, fill.
// Depends on tfl_pkg.
`default_nettype none

module tfl_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tfl_pkg::tfl_req_t      req,
    output tfl_pkg::tfl_rsp_t      rsp
);
    import tfl_pkg::*;

    logic [PAGE_W-1:0]  tag_reg   [TLB_ENTRIES];
    logic [PAGE_W-1:0]  tag_next  [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_reg [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_next[TLB_ENTRIES];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [TLB_ENTRIES-1:0] match;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       last_idx;
    logic                   full;

    // Parallel compare over occupied slots
    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match[i] = (COUNT_W'(i) < count_reg) && (tag_reg[i] == req.page);
        end
    end

    // Oldest match wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit  = |match;
    assign full     = (count_reg == COUNT_W'(TLB_ENTRIES));
    assign last_idx = IDX_W'(count_reg - COUNT_W'(1));

    assign rsp.hit   = any_hit;
    assign rsp.frame = frame_reg[hit_idx];

    always_comb
    begin
        tag_next   = tag_reg;
        frame_next = frame_reg;
        count_next = count_reg;
        if (req.fire)
        begin
            if (req.fill)
            begin
                if (full)
                begin
                    // evict oldest by shifting towards slot 0
                    for (int i = 0; i < TLB_ENTRIES - 1; i++)
                    begin
                        tag_next[i]   = tag_reg[i + 1];
                        frame_next[i] = frame_reg[i + 1];
                    end
                    tag_next[TLB_ENTRIES - 1]   = req.page;
                    frame_next[TLB_ENTRIES - 1] = req.frame;
                end
                else
                begin
                    tag_next[count_reg[IDX_W-1:0]]   = req.page;
                    frame_next[count_reg[IDX_W-1:0]] = req.frame;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            else if (any_hit && req.lru)
            begin
                // hit entry moves to newest end, those above it close the gap
                for (int i = 0; i < TLB_ENTRIES - 1; i++)
                begin
                    if ((IDX_W'(i) >= hit_idx) && (IDX_W'(i) < last_idx))
                    begin
                        tag_next[i]   = tag_reg[i + 1];
                        frame_next[i] = frame_reg[i + 1];
                    end
                end
                tag_next[last_idx]   = tag_reg[hit_idx];
                frame_next[last_idx] = frame_reg[hit_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        frame_reg <= frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
